@@ sv/i64dec_pkg.sv @@
// shared constants and types for the 64-bit binary to decimal ascii converter
package i64dec_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned DIGITS    = 20;
    localparam int unsigned BCD_W     = 4 * DIGITS;
    localparam int unsigned STEP_W    = $clog2(VALUE_W);
    localparam int unsigned LEFT_W    = $clog2(DIGITS + 1);
    localparam int unsigned CHAR_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0] ALL_DIGITS = LEFT_W'(DIGITS);

    // mode bit carried with each request
    localparam logic REQ_SIGNED   = 1'b0;
    localparam logic REQ_UNSIGNED = 1'b1;

    // commands from the sequencer to the shift-add-3 unit
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_dab_ctl;

endpackage

@@ sv/i64dec_dabble.sv @@
// shift-add-3 unit: binary magnitude to packed bcd, then digit read-out from the top
module i64dec_dabble (
    input  logic                              i_clk,
    input  i64dec_pkg::t_dab_ctl              i_ctl,
    input  logic [i64dec_pkg::VALUE_W-1:0]    i_mag,
    output logic [3:0]                        o_top_digit
);
    import i64dec_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   w_corr;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_corr[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_corr[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // load, one conversion step, or move the next digit to the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_ctl.step) begin
            r_bcd <= {w_corr[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_ctl.shift) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

@@ sv/int64_to_decimal_ascii.sv @@
// top level: request sequencer and character output register of the converter
//
// Usage:
//   Slave channel: one request per value. tdata carries the 64-bit value,
//   tuser the mode bit (0 = read as two's complement, 1 = read as unsigned).
//   Master channel: the decimal text, one ascii character per beat, most
//   significant digit first, with a leading '-' for negative signed values;
//   tlast marks the final character. Zero gives the single character '0'.
//   Sequence: after a request is taken the shift-add-3 unit runs one
//   conversion step per input bit; leading zeros are then dropped at one
//   per cycle, keeping at least one digit, and a final check in the skip
//   state ends the drop; then a '-' if needed and the digits leave at one
//   per cycle while the master side does not stall. A new request is taken
//   only once the final digit has been loaded into the output register.
//   o_s_tready is high only while no request is in progress.
//   A stall on the master side holds the current character in the output
//   register and pauses the read-out; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   empties the output register.
module int64_to_decimal_ascii (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [i64dec_pkg::VALUE_W-1:0]     i_s_tdata,   // [63:0] value
    input  logic                               i_s_tuser,   // [0] req_type
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [i64dec_pkg::CHAR_W-1:0]      o_m_tdata,   // [7:0] out_char
    output logic                               o_m_tlast    // last
);
    import i64dec_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_neg, n_neg;
    logic                r_m_valid, n_m_valid;
    logic [CHAR_W-1:0]   r_m_data, n_m_data;
    logic                r_m_last, n_m_last;

    t_dab_ctl            w_ctl;
    logic [VALUE_W-1:0]  w_mag;
    logic [3:0]          w_top;
    logic                w_accept;
    logic                w_neg_in;
    logic                w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    // magnitude, with the most negative value coming out as 2^63
    assign w_neg_in = (i_s_tuser == REQ_SIGNED) && i_s_tdata[VALUE_W-1];
    assign w_mag    = w_neg_in ? (VALUE_W'(0) - i_s_tdata) : i_s_tdata;

    i64dec_dabble u_dabble (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_left    = r_left;
        n_neg     = r_neg;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        w_ctl     = '0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_neg      = w_neg_in;
                    n_step     = '0;
                    n_left     = ALL_DIGITS;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.step = 1'b1;
                n_step     = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    w_ctl.shift = 1'b1;
                    n_left      = r_left - LEFT_W'(1);
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = CHAR_MINUS;
                    n_m_last  = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_ctl.shift = 1'b1;
                    n_m_valid   = 1'b1;
                    n_m_data    = CHAR_ZERO + CHAR_W'(w_top);
                    n_m_last    = (r_left == LEFT_W'(1));
                    n_left      = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // payload and counters
    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_left   <= n_left;
        r_neg    <= n_neg;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

`ifndef SYNTHESIS
    // a taken request always starts the conversion steps
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV) && (r_step == '0) && (r_left == ALL_DIGITS))
        else $error("request taken without starting conversion");

    // only a sign or a decimal digit ever leaves the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == CHAR_MINUS) ||
                       ((o_m_tdata >= CHAR_ZERO) && (o_m_tdata <= CHAR_ZERO + 8'd9)))
        else $error("output character outside sign and digits");

    // the final digit loaded carries tlast and returns the sequencer to idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_left == LEFT_W'(1))
        |=> o_m_tvalid && o_m_tlast && (r_state == S_IDLE))
        else $error("final digit not marked last");

    // a sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata == CHAR_MINUS) |-> !o_m_tlast)
        else $error("sign marked as last character");

    // digit count stays in range during the read-out
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_SIGN || r_state == S_EMIT)
        |-> (r_left != '0) && (r_left <= ALL_DIGITS))
        else $error("digit count out of range");
`endif

endmodule

@@ dv/int64_to_decimal_ascii_test.sv @@
// self-checking testbench for the 64-bit binary to decimal ascii converter
module int64_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i64dec_pkg::*;

    localparam int unsigned RANDOM_REQS = 400;
    localparam int unsigned QUIET_FROM  = 360;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 150;
    localparam int unsigned REPORT_MAX  = 10;

    // expected decimal text of every accepted request, oldest character first
    class dec_text_board;
        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } text_char_t;

        text_char_t  due_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // work out the characters of one accepted request
        function void note_request(logic [VALUE_W-1:0] value, logic mode);
            logic [VALUE_W-1:0] mag;
            logic [CHAR_W-1:0]  digit_q[$];
            logic               neg;
            text_char_t         c;
            neg = (mode == REQ_SIGNED) && value[VALUE_W-1];
            // two's complement negation gives 2^63 for the most negative value
            mag = neg ? (~value + 64'd1) : value;
            do begin
                digit_q.push_front(CHAR_ZERO + CHAR_W'(mag % 64'd10));
                mag = mag / 64'd10;
            end while (mag != 0);
            if (neg) begin
                c.ch   = CHAR_MINUS;
                c.last = 1'b0;
                due_q.push_back(c);
            end
            foreach (digit_q[i]) begin
                c.ch   = digit_q[i];
                c.last = (i == digit_q.size() - 1);
                due_q.push_back(c);
            end
        endfunction

        // compare one emitted character with the oldest one due
        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            text_char_t c;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected character %0d last %0b", $realtime, ch, last);
                return;
            end
            c = due_q.pop_front();
            if (c.ch !== ch || c.last !== last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: character %0d last %0b, expected %0d last %0b",
                             $realtime, ch, last, c.ch, c.last);
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [VALUE_W-1:0]  i_s_tdata;   // [63:0] value
    logic                i_s_tuser;   // [0] req_type
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [CHAR_W-1:0]   o_m_tdata;   // [7:0] out_char
    logic                o_m_tlast;

    dec_text_board board;
    bit            quiet;
    int unsigned   chars_seen;
    int unsigned   reqs_sent;

    int64_to_decimal_ascii i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // offer one request, with an occasional idle burst ahead of it
    task automatic send_request(input logic [VALUE_W-1:0] value, input logic mode);
        int unsigned gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(value, mode);
        reqs_sent++;
    endtask

    // random value: full range, short, signed small negatives, powers of ten
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int unsigned        k;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: ;
            1: v = VALUE_W'($urandom_range(0, 999));
            2: v = v >> $urandom_range(0, 63);
            3: v = -VALUE_W'($urandom_range(1, 100000));
            default: begin
                p = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                v = p + VALUE_W'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        return v;
    endfunction

    // result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_char(o_m_tdata, o_m_tlast);
            chars_seen++;
        end
    end

    // receiver: random stall bursts and one long hold-off to back up the input
    initial begin
        int unsigned hold_left;
        bit          held_long;
        hold_left = 0;
        held_long = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && hold_left == 0 && !held_long && chars_seen >= 40) begin
                hold_left = HOLD_CYCLES;
                held_long = 1'b1;
            end
            if (i_rst_n && hold_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 6);
            if (hold_left != 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [VALUE_W-1:0] v;
        int unsigned        wait_cycles;
        board      = new();
        quiet      = 1'b0;
        chars_seen = 0;
        reqs_sent  = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_SIGNED;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero in both modes
        send_request(64'd0, REQ_SIGNED);
        send_request(64'd0, REQ_UNSIGNED);
        // single digits and first carries
        send_request(64'd1, REQ_SIGNED);
        send_request(64'd9, REQ_UNSIGNED);
        send_request(64'd10, REQ_SIGNED);
        send_request(64'd99, REQ_UNSIGNED);
        send_request(64'd100, REQ_SIGNED);
        // all ones: minus one when signed, largest value when unsigned
        send_request('1, REQ_SIGNED);
        send_request('1, REQ_UNSIGNED);
        // most negative signed value and the same bits unsigned
        send_request(64'h8000_0000_0000_0000, REQ_SIGNED);
        send_request(64'h8000_0000_0000_0000, REQ_UNSIGNED);
        // largest positive signed value
        send_request(64'h7FFF_FFFF_FFFF_FFFF, REQ_SIGNED);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, REQ_UNSIGNED);
        send_request(-64'd10, REQ_SIGNED);
        send_request(-64'd1000000, REQ_SIGNED);
        // twenty-digit boundary
        send_request(64'd10000000000000000000, REQ_UNSIGNED);
        send_request(64'd9999999999999999999, REQ_UNSIGNED);
        send_request(64'h5555_5555_5555_5555, REQ_SIGNED);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, REQ_SIGNED);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, REQ_UNSIGNED);

        // random requests, no idling in the last stretch
        for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
            if (n >= QUIET_FROM)
                quiet = 1'b1;
            v = pick_value();
            send_request(v, $urandom_range(0, 1) ? REQ_UNSIGNED : REQ_SIGNED);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // drain, then watch for stray characters
        wait_cycles = 0;
        while (board.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0d characters never emitted", board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("timeout after %0d requests", reqs_sent);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
sv/i64dec_pkg.sv
sv/i64dec_dabble.sv
sv/int64_to_decimal_ascii.sv
dv/int64_to_decimal_ascii_test.sv
